// File: rtl/piecewise_linear_integral_top_assert.svh
// assertion macros used by the checker file rtl/pli_checker.sv
`ifndef PIECEWISE_LINEAR_INTEGRAL_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTEGRAL_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pli assertion failed");

// next-cycle implication
`define PLI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pli assertion failed");

`endif

// File: rtl/pli_pkg.sv
`default_nettype none
package pli_pkg;

    localparam int MAX_KNOTS_DEF = 64;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 32;
    localparam int AREA_W = 48;
    localparam int CFG_W  = 7;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_LOAD  = 2'd0;
    localparam mode_t MODE_EVAL  = 2'd1;
    localparam mode_t MODE_SWEEP = 2'd2;

endpackage
`default_nettype wire

// File: rtl/pli_ram.sv
`default_nettype none
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/piecewise_linear_integral_top.sv
`default_nettype none
// Cumulative integral of a piecewise-linear function over a sweep of points. Knots
// (position, height, Q16.16) are loaded one word per entry into a single RAM that
// has no reset; entries must be written before they are used. An evaluate first
// fetches the current interval, then passes each whole interval (RAM read, shared
// 34x34 multiplier, area update), then computes the partial area inside the final
// interval with a bit-serial divider that yields 49 quotient bits, one per cycle; a
// point beyond the last knot is answered without the partial-area steps.
module piecewise_linear_integral_top #(
    parameter int MAX_KNOTS = pli_pkg::MAX_KNOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pli_pkg::MODE_W-1:0]        mode,
    input  logic [pli_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [pli_pkg::POS_W-1:0]  knot_position,
    input  logic signed [pli_pkg::POS_W-1:0]  knot_height,
    input  logic signed [pli_pkg::POS_W-1:0]  point,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pli_pkg::AREA_W-1:0] integral_value,
    output logic                              beyond_last_knot,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pli_pkg::CFG_W-1:0]         cfg_data
);

    import pli_pkg::*;

    localparam int AW    = $clog2(MAX_KNOTS);
    localparam int CNT_W = $clog2(MAX_KNOTS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IXW   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RDL    = 5'd1;
    localparam logic [4:0] ST_RDR    = 5'd2;
    localparam logic [4:0] ST_CHK    = 5'd3;
    localparam logic [4:0] ST_PASS1  = 5'd4;
    localparam logic [4:0] ST_PASS2  = 5'd5;
    localparam logic [4:0] ST_M1     = 5'd6;
    localparam logic [4:0] ST_M2     = 5'd7;
    localparam logic [4:0] ST_M3     = 5'd8;
    localparam logic [4:0] ST_M4     = 5'd9;
    localparam logic [4:0] ST_M5     = 5'd10;
    localparam logic [4:0] ST_M6     = 5'd11;
    localparam logic [4:0] ST_M7     = 5'd12;
    localparam logic [4:0] ST_DIVSET = 5'd13;
    localparam logic [4:0] ST_DIV    = 5'd14;
    localparam logic [4:0] ST_FIN    = 5'd15;
    localparam logic [4:0] ST_OUT    = 5'd16;

    localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    // control
    logic [4:0]              state_reg, state_next;
    logic [AW-1:0]           ptr_reg, ptr_next;
    logic [AREA_W-1:0]       area_reg, area_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // payload
    logic [31:0]             x_reg, x_next;
    logic [31:0]             kl_reg, kl_next, el_reg, el_next;
    logic [31:0]             kr_reg, kr_next, er_reg, er_next;
    logic [32:0]             dk_reg, dk_next, dl_reg, dl_next;
    logic [33:0]             mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [67:0]             mul_p_reg, mul_p_next;
    logic [66:0]             inner_reg, inner_next;
    logic [99:0]             num_reg, num_next;
    logic                    neg_reg, neg_next, sat_reg, sat_next;
    logic [32:0]             absdk_reg, absdk_next;
    logic [32:0]             rem_reg, rem_next;
    logic [48:0]             quo_reg, quo_next;
    logic [AREA_W-1:0]       res_reg, res_next;
    logic                    res_beyond_reg, res_beyond_next;
    logic [AREA_W-1:0]       out_value_reg, out_value_next;
    logic                    out_beyond_reg, out_beyond_next;

    // ram
    logic                    wr_en;
    logic [AW-1:0]           rd_addr;
    logic [63:0]             rd_data;
    logic [IXW-1:0]          idx_ext;

    logic                    accept;
    logic [CNT_W-1:0]        last_iv;
    logic [CNT_W-1:0]        ptr_ext;
    logic [CMP_W-1:0]        cfg_ext;
    logic [31:0]             kr_rd, er_rd;
    logic                    x_gt_kr;

    logic [65:0]             pass_adj;
    logic [48:0]             pass_inc;
    logic [49:0]             pass_sum;
    logic [99:0]             num_mag;
    logic [82:0]             num_shr;
    logic [33:0]             div_try;
    logic [50:0]             q_signed;
    logic [50:0]             fin_sum;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid        = out_valid_reg;
    assign integral_value   = out_value_reg;
    assign beyond_last_knot = out_beyond_reg;

    assign idx_ext = IXW'(entry_index);
    assign wr_en   = accept && (mode == MODE_LOAD) && (idx_ext < IXW'(MAX_KNOTS));
    assign last_iv = count_reg - CNT_W'(2);
    assign ptr_ext = CNT_W'(ptr_reg);
    assign cfg_ext = CMP_W'(cfg_data);
    assign kr_rd   = rd_data[63:32];
    assign er_rd   = rd_data[31:0];
    assign x_gt_kr = $signed(x_reg) > $signed(kr_rd);

    pli_ram #(
        .WIDTH (64),
        .DEPTH (MAX_KNOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data ({knot_position, knot_height}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_RDR:   rd_addr = ptr_reg + AW'(1);
            ST_PASS2: rd_addr = ptr_reg + AW'(2);
            default:  rd_addr = ptr_reg;
        endcase
    end

    // shared multiplier, registered product
    assign mul_p_next = $signed({{34{mul_a_reg[33]}}, mul_a_reg})
                      * $signed({{34{mul_b_reg[33]}}, mul_b_reg});

    // whole interval area, truncated toward zero
    assign pass_adj = mul_p_reg[65:0] + (mul_p_reg[65] ? 66'h1FFFF : 66'd0);
    assign pass_inc = pass_adj[65:17];
    assign pass_sum = {{2{area_reg[AREA_W-1]}}, area_reg} + {pass_inc[48], pass_inc};

    assign num_mag = num_reg[99] ? (~num_reg + 100'd1) : num_reg;
    assign num_shr = num_mag[99:17];
    assign div_try = {rem_reg, quo_reg[48]};

    assign q_signed = neg_reg ? (~{2'b00, quo_reg} + 51'd1) : {2'b00, quo_reg};
    assign fin_sum  = {{3{area_reg[AREA_W-1]}}, area_reg} + q_signed;

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        area_next       = area_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        kl_next         = kl_reg;
        el_next         = el_reg;
        kr_next         = kr_reg;
        er_next         = er_reg;
        dk_next         = dk_reg;
        dl_next         = dl_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        inner_next      = inner_reg;
        num_next        = num_reg;
        neg_next        = neg_reg;
        sat_next        = sat_reg;
        absdk_next      = absdk_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        res_next        = res_reg;
        res_beyond_next = res_beyond_reg;
        out_value_next  = out_value_reg;
        out_beyond_next = out_beyond_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_ext < CMP_W'(2))
                count_next = CNT_W'(2);
            else if (cfg_ext > CMP_W'(MAX_KNOTS))
                count_next = CNT_W'(MAX_KNOTS);
            else
                count_next = CNT_W'(cfg_ext);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_SWEEP)
                    begin
                        ptr_next  = '0;
                        area_next = '0;
                    end
                    else if (mode == MODE_EVAL)
                    begin
                        x_next = point;
                        if (ptr_ext > last_iv)
                        begin
                            res_next        = '0;
                            res_beyond_next = 1'b1;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_RDL;
                        end
                    end
                end
            end
            ST_RDL:
            begin
                state_next = ST_RDR;
            end
            ST_RDR:
            begin
                kl_next    = rd_data[63:32];
                el_next    = rd_data[31:0];
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                kr_next = kr_rd;
                er_next = er_rd;
                if ((ptr_ext < last_iv) && x_gt_kr)
                begin
                    mul_a_next = {{2{el_reg[31]}}, el_reg} + {{2{er_rd[31]}}, er_rd};
                    mul_b_next = {{2{kr_rd[31]}}, kr_rd} - {{2{kl_reg[31]}}, kl_reg};
                    state_next = ST_PASS1;
                end
                else if (x_gt_kr)
                begin
                    res_next        = '0;
                    res_beyond_next = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                begin
                    dk_next    = {kr_rd[31], kr_rd} - {kl_reg[31], kl_reg};
                    dl_next    = {x_reg[31], x_reg} - {kl_reg[31], kl_reg};
                    mul_a_next = {{2{el_reg[31]}}, el_reg};
                    // dk + dr = 2*kr - kl - x
                    mul_b_next = {kr_rd[31], kr_rd, 1'b0}
                               - {{2{kl_reg[31]}}, kl_reg}
                               - {{2{x_reg[31]}}, x_reg};
                    state_next = ST_M1;
                end
            end
            ST_PASS1:
            begin
                state_next = ST_PASS2;
            end
            ST_PASS2:
            begin
                if (pass_sum[49:47] == 3'b000 || pass_sum[49:47] == 3'b111)
                    area_next = pass_sum[AREA_W-1:0];
                else
                    area_next = pass_sum[49] ? AREA_MIN : AREA_MAX;
                ptr_next   = ptr_reg + AW'(1);
                kl_next    = kr_reg;
                el_next    = er_reg;
                state_next = ST_CHK;
            end
            ST_M1:
            begin
                mul_a_next = {{2{er_reg[31]}}, er_reg};
                mul_b_next = {dl_reg[32], dl_reg};
                state_next = ST_M2;
            end
            ST_M2:
            begin
                inner_next = mul_p_reg[66:0];
                state_next = ST_M3;
            end
            ST_M3:
            begin
                inner_next = inner_reg + mul_p_reg[66:0];
                state_next = ST_M4;
            end
            ST_M4:
            begin
                mul_a_next = {dl_reg[32], dl_reg};
                mul_b_next = {1'b0, inner_reg[32:0]};
                state_next = ST_M5;
            end
            ST_M5:
            begin
                mul_b_next = inner_reg[66:33];
                state_next = ST_M6;
            end
            ST_M6:
            begin
                num_next   = {{32{mul_p_reg[67]}}, mul_p_reg};
                state_next = ST_M7;
            end
            ST_M7:
            begin
                num_next   = num_reg + {mul_p_reg[66:0], 33'd0};
                state_next = ST_DIVSET;
            end
            ST_DIVSET:
            begin
                sat_next = 1'b0;
                if (dk_reg == '0)
                begin
                    // zero spacing gives no partial area
                    neg_next   = 1'b0;
                    quo_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    neg_next   = num_reg[99] ^ dk_reg[32];
                    absdk_next = dk_reg[32] ? (~dk_reg + 33'd1) : dk_reg;
                    if (num_shr[82:49] >= {1'b0, absdk_next})
                    begin
                        // quotient of 2^49 or more always saturates
                        sat_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        rem_next   = num_shr[81:49];
                        quo_next   = num_shr[48:0];
                        cnt_next   = 6'd49;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_try >= {1'b0, absdk_reg})
                begin
                    rem_next = 33'(div_try - {1'b0, absdk_reg});
                    quo_next = {quo_reg[47:0], 1'b1};
                end
                else
                begin
                    rem_next = div_try[32:0];
                    quo_next = {quo_reg[47:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                res_beyond_next = 1'b0;
                priority if (sat_reg)
                    res_next = neg_reg ? AREA_MIN : AREA_MAX;
                else if (fin_sum[50:47] == 4'b0000 || fin_sum[50:47] == 4'b1111)
                    res_next = fin_sum[AREA_W-1:0];
                else
                    res_next = fin_sum[50] ? AREA_MIN : AREA_MAX;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_reg;
                    out_beyond_next = res_beyond_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            area_reg      <= '0;
            count_reg     <= CNT_W'(2);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            area_reg      <= area_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        kl_reg         <= kl_next;
        el_reg         <= el_next;
        kr_reg         <= kr_next;
        er_reg         <= er_next;
        dk_reg         <= dk_next;
        dl_reg         <= dl_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        mul_p_reg      <= mul_p_next;
        inner_reg      <= inner_next;
        num_reg        <= num_next;
        neg_reg        <= neg_next;
        sat_reg        <= sat_next;
        absdk_reg      <= absdk_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        res_reg        <= res_next;
        res_beyond_reg <= res_beyond_next;
        out_value_reg  <= out_value_next;
        out_beyond_reg <= out_beyond_next;
    end

endmodule
`default_nettype wire

// File: rtl/pli_checker.sv
`default_nettype none
`include "piecewise_linear_integral_top_assert.svh"
module pli_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [pli_pkg::MODE_W-1:0]        mode,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [pli_pkg::AREA_W-1:0] integral_value,
    input logic                              beyond_last_knot
);

    import pli_pkg::*;

    // a waiting word holds until taken
    `PLI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `PLI_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(integral_value))
    // an evaluate keeps the input side busy in the next cycle
    `PLI_ASSERT_NXT(a_eval_busy, in_valid && !in_stall && (mode == MODE_EVAL), in_stall)
    // beyond the last knot the value is zero
    `PLI_ASSERT_IMP(a_beyond_zero, out_valid && beyond_last_knot, integral_value == '0)

endmodule

bind piecewise_linear_integral_top pli_checker u_pli_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .integral_value   (integral_value),
    .beyond_last_knot (beyond_last_knot)
);
`default_nettype wire

// File: bench/integral_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module integral_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [pli_pkg::MODE_W-1:0]        mode,
    input  logic [pli_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [pli_pkg::POS_W-1:0]  knot_position,
    input  logic signed [pli_pkg::POS_W-1:0]  knot_height,
    input  logic signed [pli_pkg::POS_W-1:0]  point,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [pli_pkg::AREA_W-1:0] integral_value,
    input  logic                              beyond_last_knot,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [pli_pkg::CFG_W-1:0]         cfg_data,
    output int                                fail_count,
    output int                                pending_count,
    output int                                value_count,
    output int                                beyond_count
);
    import pli_pkg::*;

    localparam logic signed [127:0] AREA_MAX = (128'sd1 <<< 47) - 1;
    localparam logic signed [127:0] AREA_MIN = -(128'sd1 <<< 47);

    typedef struct packed {
        logic signed [AREA_W-1:0] value;
        logic                     beyond;
    } integral_word_t;

    logic signed [31:0] knot_pos [MAX_KNOTS_DEF];
    logic signed [31:0] knot_hgt [MAX_KNOTS_DEF];
    int unsigned        cur_interval;
    logic signed [AREA_W-1:0] area_acc;
    int unsigned        knots_used;
    integral_word_t     expected_words [$];

    function automatic logic signed [AREA_W-1:0] clamp48(input logic signed [127:0] v);
        if (v > AREA_MAX)
            return AREA_MAX[AREA_W-1:0];
        if (v < AREA_MIN)
            return AREA_MIN[AREA_W-1:0];
        return v[AREA_W-1:0];
    endfunction

    // signed division rounded toward zero
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] q;
        q = (n < 0 ? -n : n) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic integral_word_t evaluate_point(input logic signed [31:0] x);
        integral_word_t      w;
        int unsigned         last;
        logic signed [127:0] kl, kr, el, er, dk, dl, dr, num, part;
        w.value = '0;
        w.beyond = 1'b1;
        last = knots_used - 2;
        if (cur_interval > last)
            return w;
        while (cur_interval < last && x > knot_pos[cur_interval+1]) begin
            dk = 128'(knot_pos[cur_interval+1]) - 128'(knot_pos[cur_interval]);
            el = 128'(knot_hgt[cur_interval]) + 128'(knot_hgt[cur_interval+1]);
            area_acc = clamp48(128'(area_acc) + div_trunc(el * dk, 128'sd1 <<< 17));
            cur_interval++;
        end
        kl = knot_pos[cur_interval];
        kr = knot_pos[cur_interval+1];
        if (128'(x) > kr)
            return w;
        el = knot_hgt[cur_interval];
        er = knot_hgt[cur_interval+1];
        dk = kr - kl;
        dl = 128'(x) - kl;
        dr = kr - 128'(x);
        part = 0;
        if (dk != 0) begin
            num = dl * (el * (dk + dr) + er * dl);
            if (dk < 0) begin
                num = -num;
                dk = -dk;
            end
            part = div_trunc(num, dk <<< 17);
        end
        w.value = clamp48(128'(area_acc) + part);
        w.beyond = 1'b0;
        return w;
    endfunction

    initial begin
        fail_count = 0;
        pending_count = 0;
        value_count = 0;
        beyond_count = 0;
        cur_interval = 0;
        area_acc = '0;
        knots_used = 2;
        foreach (knot_pos[i])
        begin
            knot_pos[i] = '0;
            knot_hgt[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        integral_word_t exp_w;
        int unsigned    v;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                v = cfg_data;
                knots_used = v < 2 ? 2 : (v > MAX_KNOTS_DEF ? MAX_KNOTS_DEF : v);
            end
            if (in_valid && !in_stall) begin
                case (mode)
                    MODE_LOAD:
                    begin
                        knot_pos[entry_index] = knot_position;
                        knot_hgt[entry_index] = knot_height;
                    end
                    MODE_SWEEP:
                    begin
                        cur_interval = 0;
                        area_acc = '0;
                    end
                    MODE_EVAL:
                        expected_words.push_back(evaluate_point(point));
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word value=%0d beyond=%0b", $time,
                             integral_value, beyond_last_knot);
                    fail_count++;
                end
                else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.beyond) beyond_count++; else value_count++;
                    if (exp_w.value !== integral_value) begin
                        $display("%0t: integral_value expected %0d actual %0d", $time,
                                 exp_w.value, integral_value);
                        fail_count++;
                    end
                    if (exp_w.beyond !== beyond_last_knot) begin
                        $display("%0t: beyond_last_knot expected %0b actual %0b", $time,
                                 exp_w.beyond, beyond_last_knot);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_words.size();
        end
    end
endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import pli_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    mode_t               mode = MODE_LOAD;
    logic [IDX_W-1:0]    entry_index = '0;
    logic signed [31:0]  knot_position = '0;
    logic signed [31:0]  knot_height = '0;
    logic signed [31:0]  point = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [AREA_W-1:0] integral_value;
    logic                beyond_last_knot;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;
    int                  fail_count, pending_count, value_count, beyond_count;
    int                  idle_cycles = 0;
    int                  item_count = 0;
    bit                  calm = 1'b0;
    int                  knots_now = 2;
    logic signed [31:0]  knot_x [MAX_KNOTS_DEF];

    always #5 clk = ~clk;

    piecewise_linear_integral_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .entry_index(entry_index), .knot_position(knot_position),
        .knot_height(knot_height), .point(point),
        .out_valid(out_valid), .out_stall(out_stall),
        .integral_value(integral_value), .beyond_last_knot(beyond_last_knot),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    integral_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .entry_index(entry_index), .knot_position(knot_position),
        .knot_height(knot_height), .point(point),
        .out_valid(out_valid), .out_stall(out_stall),
        .integral_value(integral_value), .beyond_last_knot(beyond_last_knot),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .value_count(value_count), .beyond_count(beyond_count)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // valid stays high between back-to-back words and drops only for a gap
    task automatic send_word(input mode_t m, input int idx, input logic signed [31:0] kp,
                             input logic signed [31:0] kh, input logic signed [31:0] pt);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        entry_index <= idx[IDX_W-1:0];
        knot_position <= kp;
        knot_height <= kh;
        point <= pt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        item_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_count(input int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (v < 2) knots_now = 2; else if (v > 64) knots_now = 64; else knots_now = v;
    endtask

    // non-decreasing knots with random spacing up to span, random heights
    task automatic load_table(input int n, input int span);
        logic signed [31:0] x;
        x = $urandom_range(0, 1 << 20) - (1 << 19);
        for (int i = 0; i < n; i++) begin
            knot_x[i] = x;
            send_word(MODE_LOAD, i, x, $urandom, 0);
            x = x + $urandom_range(0, span);
        end
    endtask

    task automatic sweep(input int n);
        logic signed [31:0] p, hi;
        send_word(MODE_SWEEP, $urandom, $urandom, $urandom, $urandom);
        hi = knot_x[knots_now-1];
        p = knot_x[0] - $urandom_range(0, 1 << 16);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(MODE_EVAL, $urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(0, 29) == 0)
                send_word(2'd3, $urandom, $urandom, $urandom, $urandom);
            else begin
                send_word(MODE_EVAL, $urandom, $urandom, $urandom, p);
                p = p + $urandom_range(0, (hi - knot_x[0]) / n + 2);
            end
        end
    endtask

    initial
    begin
        int n;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes of fields, all modes
        send_word(MODE_LOAD, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0);
        send_word(MODE_LOAD, 1, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_word(MODE_EVAL, 63, -1, -1, 32'sh8000_0000);
        send_word(MODE_EVAL, 0, 0, 0, 0);
        send_word(MODE_EVAL, 0, 0, 0, 32'sh7fff_ffff);
        send_word(MODE_SWEEP, 63, -1, -1, -1);
        send_word(MODE_LOAD, 1, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_word(MODE_LOAD, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
        // zero spacing
        send_word(MODE_EVAL, 0, 0, 0, 32'sh8000_0000);
        send_word(MODE_EVAL, 0, 0, 0, 32'sh7fff_ffff);
        send_word(2'd3, 63, -1, -1, -1);
        // decreasing knots
        send_word(MODE_LOAD, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_word(MODE_SWEEP, 0, 0, 0, 0);
        send_word(MODE_EVAL, 0, 0, 0, 0);
        send_word(MODE_EVAL, 0, 0, 0, 32'sh8000_0000);
        for (int i = 0; i < 64; i++) begin
            knot_x[i] = (i - 32) <<< 16;
            send_word(MODE_LOAD, i, (i - 32) <<< 16, 32'sh7fff_ffff - i, 0);
        end
        write_count(127);
        send_word(MODE_SWEEP, 0, 0, 0, 0);
        send_word(MODE_EVAL, 0, 0, 0, 31 <<< 16);
        send_word(MODE_EVAL, 0, 0, 0, 0);
        send_word(MODE_EVAL, 0, 0, 0, 32'sh7fff_ffff);
        // pointer past the last interval after lowering the count
        write_count(0);
        send_word(MODE_EVAL, 0, 0, 0, 0);
        write_count(1);

        while (item_count < 1300) begin
            case ($urandom_range(0, 3))
                0: n = 2;
                1: n = $urandom_range(2, 8);
                2: n = $urandom_range(2, 24);
                default: n = 64;
            endcase
            write_count(n);
            load_table(n, $urandom_range(0, 1) ? 1 << 17 : 32'h0fff_ffff / n);
            if (item_count > 1100) calm = 1'b1;
            sweep($urandom_range(4, 40));
        end
        drain();
        $display("%0d input words, %0d in-range and %0d beyond-last-knot results checked",
                 item_count, value_count, beyond_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("%0d failures", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/piecewise_linear_integral_top.sv
rtl/pli_checker.sv
bench/integral_checker.sv
bench/testbench.sv
